// ----- src/obms_pkg.sv -----
`timescale 1ns / 1ps

package obms_pkg;

  // Width of the window and sample counters
  localparam int unsigned CntW = 16;

  // Register and field widths
  localparam int unsigned WinW     = 16;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxPressWindow   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxReleaseWindow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxModeLimit     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [WinW-1:0]  PressWindowRst   = 16'd100;
  localparam logic [WinW-1:0]  ReleaseWindowRst = 16'd100;
  localparam logic [ModeW-1:0] ModeLimitRst     = 4'd3;

  // Phase codes as seen on the result word
  localparam logic [PhaseW-1:0] PhaseCodeIdle  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseCodeArmed = 2'd1;
  localparam logic [PhaseW-1:0] PhaseCodeCount = 2'd2;
  localparam logic [PhaseW-1:0] PhaseCodeDone  = 2'd3;

  // Item operation codes
  localparam logic OpPinChange = 1'b0;
  localparam logic OpTick      = 1'b1;

  typedef struct packed {
    logic [WinW-1:0]  press_window;
    logic [WinW-1:0]  release_window;
    logic [ModeW-1:0] mode_limit;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [PhaseW-1:0] phase;
    logic              expected_pressed;
    logic              press_accepted;
    logic              event_rejected;
  } result_t;

endpackage

// ----- src/oversampled_button_mode_selector.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// input     in         in_valid_i / in_stall_o    operation_i, switch_level_i
// result    out        out_valid_o / out_stall_i  mode_o, phase_o, expected_pressed_o,
//                                                 press_accepted_o, event_rejected_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the result side does not stall; a result word passes
// from the input register through the qualifier logic into the result register.
// Reset clears the qualifier to idle, the counts and mode to zero, the position to
// released, and loads the window and limit registers with their defaults.
// A stalled result register holds its word; the input register then fills and stalls.
// Config words are taken every cycle.

module oversampled_button_mode_selector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic                           switch_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [obms_pkg::ModeW-1:0]     mode_o,
  output logic [obms_pkg::PhaseW-1:0]    phase_o,
  output logic                           expected_pressed_o,
  output logic                           press_accepted_o,
  output logic                           event_rejected_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [obms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [obms_pkg::CfgDataW-1:0]  cfg_data_i
);

  obms_pkg::cfg_t    cfg;
  obms_pkg::result_t result;
  obms_pkg::result_t result_q;
  logic              in_valid_q;
  logic              operation_q;
  logic              level_q;
  logic              out_valid_q;
  logic              advance;

  obms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held input word into the result register when it has room
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;

  obms_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .operation_i    (operation_q),
    .switch_level_i (level_q),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      operation_q <= operation_i;
      level_q     <= switch_level_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = result_q.mode;
  assign phase_o            = result_q.phase;
  assign expected_pressed_o = result_q.expected_pressed;
  assign press_accepted_o   = result_q.press_accepted;
  assign event_rejected_o   = result_q.event_rejected;

  // An empty result register never stalls the input side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // A stalled result word is never lost
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result dropped");

  // A stalled input word stays in the input register
  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled input dropped");

endmodule

// ----- src/obms_cfg_regs.sv -----
`timescale 1ns / 1ps

module obms_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [obms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [obms_pkg::CfgDataW-1:0]  cfg_data_i,
  output obms_pkg::cfg_t                 cfg_o
);

  obms_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  // Take a write word every cycle
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Decode the register index; unknown indexes drop the word
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        obms_pkg::CfgIdxPressWindow:   cfg_d.press_window   = cfg_data_i[obms_pkg::WinW-1:0];
        obms_pkg::CfgIdxReleaseWindow: cfg_d.release_window = cfg_data_i[obms_pkg::WinW-1:0];
        obms_pkg::CfgIdxModeLimit:     cfg_d.mode_limit     = cfg_data_i[obms_pkg::ModeW-1:0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_window   <= obms_pkg::PressWindowRst;
      cfg_q.release_window <= obms_pkg::ReleaseWindowRst;
      cfg_q.mode_limit     <= obms_pkg::ModeLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/obms_core.sv -----
`timescale 1ns / 1ps

module obms_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                operation_i,
  input  logic                switch_level_i,
  input  obms_pkg::cfg_t      cfg_i,
  output obms_pkg::result_t   result_o
);

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhArmed = 4'b0010,
    PhCount = 4'b0100,
    PhDone  = 4'b1000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [obms_pkg::CntW-1:0]       window_q, window_d;
  logic [obms_pkg::CntW-1:0]       needed_q, needed_d;
  logic                            pressed_q, pressed_d;
  logic [obms_pkg::ModeW-1:0]      mode_q, mode_d;
  logic                            accepted, rejected;
  logic [obms_pkg::WinW-1:0]       win_sel;
  logic [obms_pkg::ModeW:0]        mode_inc;
  logic                            level_match;
  logic [obms_pkg::PhaseW-1:0]     phase_code;

  // Window of the edge being qualified, picked by the position before the flip
  assign win_sel     = pressed_q ? cfg_i.release_window : cfg_i.press_window;
  assign mode_inc    = {1'b0, mode_q} + {{obms_pkg::ModeW{1'b0}}, 1'b1};
  // Low level means pressed
  assign level_match = pressed_q ? ~switch_level_i : switch_level_i;

  // Advance the qualifier by one word
  always_comb begin
    phase_d   = phase_q;
    window_d  = window_q;
    needed_d  = needed_q;
    pressed_d = pressed_q;
    mode_d    = mode_q;
    accepted  = 1'b0;
    rejected  = 1'b0;
    if (operation_i == obms_pkg::OpPinChange) begin
      if (phase_q == PhIdle) phase_d = PhArmed;
    end else begin
      unique case (phase_q)
        PhArmed: begin
          phase_d   = PhCount;
          pressed_d = ~pressed_q;
          window_d  = obms_pkg::CntW'(win_sel);
          needed_d  = obms_pkg::CntW'(win_sel >> 1);
        end
        PhCount: begin
          priority if (window_q != '0) begin
            window_d = window_q - obms_pkg::CntW'(1);
            if (needed_q != '0 && level_match) needed_d = needed_q - obms_pkg::CntW'(1);
          end else if (needed_q != '0) begin
            phase_d  = PhIdle;
            window_d = '0;
            needed_d = '0;
            rejected = 1'b1;
          end else begin
            phase_d = PhDone;
          end
        end
        PhDone: begin
          phase_d = PhIdle;
          if (pressed_q) begin
            accepted = 1'b1;
            if (mode_inc > {1'b0, cfg_i.mode_limit}) begin
              mode_d    = '0;
              pressed_d = 1'b0;
            end else begin
              mode_d = mode_inc[obms_pkg::ModeW-1:0];
            end
          end
        end
        PhIdle:  phase_d = PhIdle;
        default: phase_d = PhIdle;
      endcase
    end
  end

  // Map the one-hot phase to its result code
  always_comb begin
    unique case (phase_d)
      PhIdle:  phase_code = obms_pkg::PhaseCodeIdle;
      PhArmed: phase_code = obms_pkg::PhaseCodeArmed;
      PhCount: phase_code = obms_pkg::PhaseCodeCount;
      PhDone:  phase_code = obms_pkg::PhaseCodeDone;
      default: phase_code = obms_pkg::PhaseCodeIdle;
    endcase
  end

  assign result_o.mode             = mode_d;
  assign result_o.phase            = phase_code;
  assign result_o.expected_pressed = pressed_d;
  assign result_o.press_accepted   = accepted;
  assign result_o.event_rejected   = rejected;

  // Hold state unless a word passes through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      window_q  <= '0;
      needed_q  <= '0;
      pressed_q <= 1'b0;
      mode_q    <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      window_q  <= window_d;
      needed_q  <= needed_d;
      pressed_q <= pressed_d;
      mode_q    <= mode_d;
    end
  end

  // A mode step only comes from the confirmed phase with a pressed position
  a_accept_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && accepted |-> phase_q == PhDone && pressed_q)
    else $error("mode advanced outside confirmed press");

  // A rejection leaves both counts cleared and the qualifier idle
  a_reject_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rejected |=> window_q == '0 && needed_q == '0 && phase_q == PhIdle)
    else $error("rejection did not clear the qualifier");

  // Mode only changes when a press is accepted
  a_mode_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && accepted) |=> $stable(mode_q))
    else $error("mode changed without an accepted press");

endmodule

// ----- dv/oversampled_button_mode_selector_test.sv -----
`timescale 1ns / 1ps

module oversampled_button_mode_selector_test;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PrintLimit = 40;

  typedef struct packed {
    logic op;
    logic level;
    logic hold;
  } stim_word_t;

  // DUT ports, the inputs all known from time zero
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          operation_i    = obms_pkg::OpPinChange;
  logic                          switch_level_i = 1'b1;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic [obms_pkg::ModeW-1:0]    mode_o;
  logic [obms_pkg::PhaseW-1:0]   phase_o;
  logic                          expected_pressed_o;
  logic                          press_accepted_o;
  logic                          event_rejected_o;
  logic                          cfg_valid_i    = 1'b0;
  logic                          cfg_ready_o;
  logic [obms_pkg::CfgIdxW-1:0]  cfg_index_i    = obms_pkg::CfgIdxPressWindow;
  logic [obms_pkg::CfgDataW-1:0] cfg_data_i     = '0;

  // Shadow of the qualifier and its registers
  obms_pkg::cfg_t              cfg_shadow       = {obms_pkg::PressWindowRst,
                                                   obms_pkg::ReleaseWindowRst,
                                                   obms_pkg::ModeLimitRst};
  logic [obms_pkg::PhaseW-1:0] qual_phase       = obms_pkg::PhaseCodeIdle;
  logic [obms_pkg::CntW-1:0]   win_left         = '0;
  logic [obms_pkg::CntW-1:0]   need_left        = '0;
  logic                        believed_pressed = 1'b0;
  logic [obms_pkg::ModeW-1:0]  cur_mode         = '0;

  stim_word_t          pending_words[$];
  obms_pkg::result_t   due_results[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned send_calm    = 0;
  int unsigned stall_calm   = 0;

  oversampled_button_mode_selector u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .switch_level_i     (switch_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .mode_o             (mode_o),
    .phase_o            (phase_o),
    .expected_pressed_o (expected_pressed_o),
    .press_accepted_o   (press_accepted_o),
    .event_rejected_o   (event_rejected_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short pauses, a few long ones, and now and then a calm stretch
  function automatic int unsigned pick_pause(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    if (r < 2) calm = $urandom_range(80, 20);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // Step the debounce qualifier by one word and queue the status it reports
  function automatic void advance_qualifier(logic op, logic level);
    obms_pkg::result_t           r;
    logic [obms_pkg::WinW-1:0]   win;
    logic [obms_pkg::ModeW:0]    next_mode;
    r = '0;
    if (op == obms_pkg::OpPinChange) begin
      if (qual_phase == obms_pkg::PhaseCodeIdle) qual_phase = obms_pkg::PhaseCodeArmed;
    end else begin
      case (qual_phase)
        obms_pkg::PhaseCodeArmed: begin
          // flip the position and load the window of the new edge
          qual_phase = obms_pkg::PhaseCodeCount;
          win = believed_pressed ? cfg_shadow.release_window : cfg_shadow.press_window;
          believed_pressed = ~believed_pressed;
          win_left = obms_pkg::CntW'(win);
          need_left = obms_pkg::CntW'(win >> 1);
        end
        obms_pkg::PhaseCodeCount: begin
          if (win_left != '0) begin
            win_left = win_left - obms_pkg::CntW'(1);
            // a low pin is a pressed sample
            if (need_left != '0 && level != believed_pressed)
              need_left = need_left - obms_pkg::CntW'(1);
          end else if (need_left != '0) begin
            qual_phase = obms_pkg::PhaseCodeIdle;
            win_left = '0;
            need_left = '0;
            r.event_rejected = 1'b1;
          end else begin
            qual_phase = obms_pkg::PhaseCodeDone;
          end
        end
        obms_pkg::PhaseCodeDone: begin
          qual_phase = obms_pkg::PhaseCodeIdle;
          if (believed_pressed) begin
            r.press_accepted = 1'b1;
            next_mode = {1'b0, cur_mode} + (obms_pkg::ModeW + 1)'(1);
            if (next_mode > {1'b0, cfg_shadow.mode_limit}) begin
              next_mode = '0;
              believed_pressed = 1'b0;
            end
            cur_mode = next_mode[obms_pkg::ModeW-1:0];
          end
        end
        default: ;
      endcase
    end
    r.mode = cur_mode;
    r.phase = qual_phase;
    r.expected_pressed = believed_pressed;
    due_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    obms_pkg::result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result word with none due", 1, 0);
      return;
    end
    want = due_results.pop_front();
    if (mode_o != want.mode)
      report_mismatch("mode", int'(mode_o), int'(want.mode));
    if (phase_o != want.phase)
      report_mismatch("phase", int'(phase_o), int'(want.phase));
    if (expected_pressed_o != want.expected_pressed)
      report_mismatch("expected_pressed", int'(expected_pressed_o),
                      int'(want.expected_pressed));
    if (press_accepted_o != want.press_accepted)
      report_mismatch("press_accepted", int'(press_accepted_o), int'(want.press_accepted));
    if (event_rejected_o != want.event_rejected)
      report_mismatch("event_rejected", int'(event_rejected_o), int'(want.event_rejected));
  endtask

  // Input side: present queued words, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_qualifier(operation_i, switch_level_i);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].hold && due_results.size() != 0)) begin
          in_valid_i <= 1'b1;
          operation_i <= pending_words[0].op;
          switch_level_i <= pending_words[0].level;
          void'(pending_words.pop_front());
          gap_left <= pick_pause(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: stall at random, check each word taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= pick_pause(stall_calm);
      end
    end
  end

  task automatic queue_word(logic op, logic level, logic hold);
    pending_words.push_back('{op: op, level: level, hold: hold});
    words_queued++;
  endtask

  // Wait until every word is taken and every status word has come back
  task automatic drain_results();
    while (words_taken != words_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [obms_pkg::CfgIdxW-1:0] idx,
                           logic [obms_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      obms_pkg::CfgIdxPressWindow:   cfg_shadow.press_window = data;
      obms_pkg::CfgIdxReleaseWindow: cfg_shadow.release_window = data;
      obms_pkg::CfgIdxModeLimit:     cfg_shadow.mode_limit = data[obms_pkg::ModeW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(int unsigned press_w, int unsigned release_w, int unsigned limit);
    drain_results();
    write_reg(obms_pkg::CfgIdxPressWindow, obms_pkg::CfgDataW'(press_w));
    write_reg(obms_pkg::CfgIdxReleaseWindow, obms_pkg::CfgDataW'(release_w));
    write_reg(obms_pkg::CfgIdxModeLimit, obms_pkg::CfgDataW'(limit));
  endtask

  // One edge: event, loading tick, then window ticks mostly at one level
  task automatic queue_sequence(int unsigned span);
    logic        bias;
    int unsigned ticks;
    queue_word(obms_pkg::OpPinChange, 1'($urandom_range(1)), $urandom_range(19) == 0);
    if ($urandom_range(3) == 0) queue_word(obms_pkg::OpPinChange, 1'($urandom_range(1)), 1'b0);
    queue_word(obms_pkg::OpTick, 1'($urandom_range(1)), 1'b0);
    bias = 1'($urandom_range(1));
    // window ticks, the confirming tick and the accepting tick, sometimes short
    ticks = span + $urandom_range(4);
    for (int unsigned k = 0; k < ticks; k++) begin
      if ($urandom_range(39) == 0)
        queue_word(obms_pkg::OpPinChange, 1'($urandom_range(1)), 1'b0);
      queue_word(obms_pkg::OpTick, ($urandom_range(9) < 8) ? bias : ~bias, 1'b0);
    end
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) queue_word(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
  endtask

  task automatic run_phase(int unsigned press_w, int unsigned release_w, int unsigned limit,
                           int unsigned words);
    int unsigned start;
    int unsigned span;
    set_regs(press_w, release_w, limit);
    span = (press_w > release_w) ? press_w : release_w;
    start = words_queued;
    while (words_queued - start < words) begin
      if ($urandom_range(4) == 0) queue_noise();
      else queue_sequence(span);
    end
  endtask

  function automatic int unsigned pick_window();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    return $urandom_range(12, 2);
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks while idle, arm, then an event while armed
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b0, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b1, 1'b0);

    // Zero windows confirm at once; a limit of zero wraps and releases
    set_regs(0, 0, 0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);

    // Rejected press, confirmed release, then an accepted press
    set_regs(2, 3, 15);
    queue_word(obms_pkg::OpPinChange, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpPinChange, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b0, 1'b0);
    queue_word(obms_pkg::OpTick, 1'b1, 1'b0);

    // Random edges under a range of settings; high limit then low to overrun the mode
    run_phase(int'(obms_pkg::PressWindowRst), int'(obms_pkg::ReleaseWindowRst),
              int'(obms_pkg::ModeLimitRst), 400);
    run_phase(1, 1, 1, 150);
    run_phase(2, 2, 15, 200);
    run_phase(1, 2, 1, 100);
    for (int p = 0; p < 7; p++) run_phase(pick_window(), pick_window(), $urandom_range(15), 130);

    // One edge into the widest window, a short stretch of its count
    set_regs(65535, 65535, 15);
    queue_sequence(20);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
